[rtl/cri_pkg.sv]
// Shared types and constants for the cable robot inverse kinematics pipeline.
// No dependencies; imported by every module of the block.
package cri_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 18;
    localparam int PRE_SHIFT    = 20;
    localparam int DW           = 17;   // width of |dx|, |dy| in half units
    localparam int CW           = 42;   // CORDIC x/y width, signed
    localparam int ZW           = 25;   // CORDIC angle accumulator width, signed
    localparam int SQW          = 2 * DW;
    localparam int RW           = 37;   // square root remainder width
    localparam int ROOTW        = SQRT_STEPS;

    localparam logic [ZW-1:0] ANG_MAX_Q16 = ZW'(90 * 65536);
    localparam logic [17:0]   LEN_MAX     = 18'd131071;

    // configuration register indexes
    localparam logic [2:0] REG_PLANE_WIDTH     = 3'd0;
    localparam logic [2:0] REG_PLANE_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_EFFECTOR_WIDTH  = 3'd2;
    localparam logic [2:0] REG_EFFECTOR_HEIGHT = 3'd3;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [16:0]       length_left;
        logic [16:0]       length_right;
        logic signed [15:0] angle_left;
        logic signed [15:0] angle_right;
    } out_t;

    typedef struct packed {
        logic [15:0] plane_width;
        logic [15:0] plane_height;
        logic [15:0] effector_width;
        logic [15:0] effector_height;
    } cfg_t;

    // after range check: magnitudes of the three deltas
    typedef struct packed {
        logic [1:0]          status;
        logic [1:0][DW-1:0]  adx;
        logic [DW-1:0]       ady;
    } front_t;

    // after squaring
    typedef struct packed {
        logic [1:0]          status;
        logic [1:0][DW-1:0]  adx;
        logic [DW-1:0]       ady;
        logic [1:0][SQW-1:0] sqx;
        logic [SQW-1:0]      sqy;
    } sq_t;

    // one lane per cable: CORDIC vectoring plus digit-by-digit square root
    typedef struct packed {
        logic [1:0]            status;
        logic [1:0][CW-1:0]    cx;
        logic [1:0][CW-1:0]    cy;
        logic [1:0][ZW-1:0]    cz;
        logic [1:0][RW-1:0]    rem;
        logic [1:0][ROOTW-1:0] root;
    } lane_t;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/cri_front.sv]
// Workspace check and cable deltas in doubled units (1/512 cm).
// Depends on cri_pkg.
module cri_front
    import cri_pkg::*;
(
    input  in_t    pos,
    input  cfg_t   cfg,
    output front_t front
);

    logic signed [18:0] x2, y2, w2, h2, ew, eh, xlim, ylim;
    logic               x_bad, y_bad;
    logic signed [18:0] dx1, dx2n, dyn;

    // limits and deltas, signed so an impossible workspace fails every point
    always_comb begin
        x2    = $signed({2'b00, pos.pos_x, 1'b0});
        y2    = $signed({2'b00, pos.pos_y, 1'b0});
        w2    = $signed({2'b00, cfg.plane_width, 1'b0});
        h2    = $signed({2'b00, cfg.plane_height, 1'b0});
        ew    = $signed({3'b000, cfg.effector_width});
        eh    = $signed({3'b000, cfg.effector_height});
        xlim  = w2 - ew;
        ylim  = h2 - eh;
        x_bad = (x2 >= xlim) || (x2 <= ew);
        y_bad = (y2 >= ylim) || (y2 <= eh);
        dx1   = x2 - ew;
        dx2n  = xlim - x2;
        dyn   = ylim - y2;
        front.status = {y_bad, x_bad};
        front.adx[0] = dx1[DW-1:0];
        front.adx[1] = dx2n[DW-1:0];
        front.ady    = dyn[DW-1:0];
    end

endmodule

[rtl/cri_step.sv]
// One pipeline step for both cables: a CORDIC vectoring iteration and,
// in the first SQRT_STEPS steps, one bit of the square root. Depends on cri_pkg.
module cri_step
    import cri_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  lane_t lane_i,
    output lane_t lane_o
);

    localparam bit DO_SQRT = (STEP < SQRT_STEPS);
    localparam int B       = DO_SQRT ? (SQRT_STEPS - 1 - STEP) : 0;

    logic signed [CW-1:0] x, y, xs, ys;
    logic signed [ZW-1:0] z;
    logic [RW-1:0]        t;
    logic [ZW-1:0]        ang;

    always_comb begin
        lane_o = lane_i;
        ang    = atan_q16(5'(STEP));
        for (int c = 0; c < 2; c++) begin
            // rotate toward the x axis; arithmetic shift floors
            x  = $signed(lane_i.cx[c]);
            y  = $signed(lane_i.cy[c]);
            z  = $signed(lane_i.cz[c]);
            xs = x >>> STEP;
            ys = y >>> STEP;
            if (y >= 0) begin
                lane_o.cx[c] = x + ys;
                lane_o.cy[c] = y - xs;
                lane_o.cz[c] = z + $signed(ang);
            end else begin
                lane_o.cx[c] = x - ys;
                lane_o.cy[c] = y + xs;
                lane_o.cz[c] = z - $signed(ang);
            end
            // square root: try root bit B
            t = (RW'(lane_i.root[c]) << (B + 1)) | (RW'(1) << (2 * B));
            if (DO_SQRT && (lane_i.rem[c] >= t)) begin
                lane_o.rem[c]  = lane_i.rem[c] - t;
                lane_o.root[c] = lane_i.root[c] | (ROOTW'(1) << B);
            end
        end
    end

endmodule

[rtl/cri_back.sv]
// Final formatting: length rounding and saturation, angle clamp and rounding,
// zeroing for out-of-range points. Depends on cri_pkg.
module cri_back
    import cri_pkg::*;
(
    input  lane_t lane,
    output out_t  res
);

    logic [ROOTW:0]       len;
    logic signed [ZW-1:0] z;
    logic [ZW-1:0]        zc;
    logic [ZW-1:0]        zr;
    logic [1:0][16:0]     lens;
    logic [1:0][15:0]     angs;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            // halves round up, then saturate
            len = ({1'b0, lane.root[c]} + (ROOTW + 1)'(1)) >> 1;
            lens[c] = (len[17:0] > LEN_MAX) ? LEN_MAX[16:0] : len[16:0];
            // clamp to 0..90 degrees, round to 8 fraction bits
            z = $signed(lane.cz[c]);
            if (z < 0) begin
                zc = '0;
            end else if (lane.cz[c] > ANG_MAX_Q16) begin
                zc = ANG_MAX_Q16;
            end else begin
                zc = lane.cz[c];
            end
            zr      = (zc + ZW'(128)) >> 8;
            angs[c] = zr[15:0];
        end
        res.status = lane.status;
        if (lane.status != 2'b00) begin
            res.length_left  = '0;
            res.length_right = '0;
            res.angle_left   = '0;
            res.angle_right  = '0;
        end else begin
            res.length_left  = lens[0];
            res.length_right = lens[1];
            res.angle_left   = $signed(angs[0]);
            res.angle_right  = $signed(angs[1]);
        end
    end

endmodule

[rtl/cable_robot_inverse_kinematics.sv]
// Top level: configuration registers and the 24-stage pipeline that chains
// cri_front, squaring, 20 cri_step stages and cri_back. Depends on cri_pkg.
//
//   Channel   Ports                           Direction  Moves
//   s_        s_valid s_ready s_data          in         one position request
//   m_        m_valid m_ready m_data          out        one result per request
//   cfg_      cfg_valid cfg_ready cfg_index   in         one register write
//             cfg_data
//
// A request passes from acceptance to m_valid through one range-check stage,
// one squaring stage, one root setup stage, 20 CORDIC stages (the first 18 also
// produce one square root bit each) and the output register.
// One request is accepted per cycle unless the pipeline is backed up; each stage holds
// its own valid bit, so a stall on m_ready fills bubbles first and then backs up stage by stage.
// Reset clears the valid bits and loads the default geometry.
module cable_robot_inverse_kinematics
    import cri_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    front_t front_next, front_reg;
    sq_t    sq_next, sq_reg;
    lane_t  lane_init;
    lane_t  lane_reg  [0:CORDIC_STEPS];
    lane_t  lane_next [0:CORDIC_STEPS-1];
    out_t   out_next, out_reg;

    logic                  front_v_reg, sq_v_reg, out_v_reg;
    logic                  lane_v_reg [0:CORDIC_STEPS];
    logic                  front_en, sq_en, out_en;
    logic [CORDIC_STEPS:0] lane_en;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plane_width     <= 16'd25600;
            cfg_reg.plane_height    <= 16'd25600;
            cfg_reg.effector_width  <= 16'd2560;
            cfg_reg.effector_height <= 16'd2560;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PLANE_WIDTH:     cfg_reg.plane_width     <= cfg_data;
                REG_PLANE_HEIGHT:    cfg_reg.plane_height    <= cfg_data;
                REG_EFFECTOR_WIDTH:  cfg_reg.effector_width  <= cfg_data;
                REG_EFFECTOR_HEIGHT: cfg_reg.effector_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        out_en = !out_v_reg || m_ready;
        lane_en[CORDIC_STEPS] = !lane_v_reg[CORDIC_STEPS] || out_en;
        for (int k = CORDIC_STEPS - 1; k >= 0; k--) begin
            lane_en[k] = !lane_v_reg[k] || lane_en[k+1];
        end
        sq_en    = !sq_v_reg || lane_en[0];
        front_en = !front_v_reg || sq_en;
    end
    assign s_ready = front_en;

    // range check and deltas
    cri_front u_front (
        .pos   (s_data),
        .cfg   (cfg_reg),
        .front (front_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_v_reg <= 1'b0;
        end else if (front_en) begin
            front_v_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (front_en) begin
            front_reg <= front_next;
        end
    end

    // squares of the deltas
    always_comb begin
        sq_next.status = front_reg.status;
        sq_next.adx    = front_reg.adx;
        sq_next.ady    = front_reg.ady;
        sq_next.sqx[0] = front_reg.adx[0] * front_reg.adx[0];
        sq_next.sqx[1] = front_reg.adx[1] * front_reg.adx[1];
        sq_next.sqy    = front_reg.ady * front_reg.ady;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= 1'b0;
        end else if (sq_en) begin
            sq_v_reg <= front_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (sq_en) begin
            sq_reg <= sq_next;
        end
    end

    // lane setup: root operand and CORDIC start vector (|dy|, |dx|)
    always_comb begin
        lane_init.status = sq_reg.status;
        for (int c = 0; c < 2; c++) begin
            lane_init.cx[c]   = CW'(sq_reg.ady) << PRE_SHIFT;
            lane_init.cy[c]   = CW'(sq_reg.adx[c]) << PRE_SHIFT;
            lane_init.cz[c]   = '0;
            lane_init.rem[c]  = RW'(sq_reg.sqx[c]) + RW'(sq_reg.sqy);
            lane_init.root[c] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_v_reg[0] <= 1'b0;
        end else if (lane_en[0]) begin
            lane_v_reg[0] <= sq_v_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (lane_en[0]) begin
            lane_reg[0] <= lane_init;
        end
    end

    // CORDIC / square root stages
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        cri_step #(
            .STEP (k)
        ) u_step (
            .lane_i (lane_reg[k]),
            .lane_o (lane_next[k])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lane_v_reg[k+1] <= 1'b0;
            end else if (lane_en[k+1]) begin
                lane_v_reg[k+1] <= lane_v_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (lane_en[k+1]) begin
                lane_reg[k+1] <= lane_next[k];
            end
        end
    end

    // output formatting and result register
    cri_back u_back (
        .lane (lane_reg[CORDIC_STEPS]),
        .res  (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_en) begin
            out_v_reg <= lane_v_reg[CORDIC_STEPS];
        end
    end
    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule
